// File: hw/rtl/pedd_pkg.sv
package pedd_pkg;

  localparam int PAL_N      = 16;
  localparam int PAL_IDX_W  = $clog2(PAL_N);
  localparam int MAX_WIDTH  = 4096;
  localparam int LINE_DEPTH = MAX_WIDTH + 2;
  localparam int LINE_AW    = $clog2(LINE_DEPTH);
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int LW_W       = 13;
  localparam int ERR_W      = 14;
  localparam int PIX_W      = 15;
  localparam int DIFF_W     = 16;
  localparam int SQ_W       = 28;
  localparam int DIST_W     = 30;
  localparam int SAT_IN_W   = 20;
  localparam int ERR_MAX    = (1 << (ERR_W - 1)) - 1;
  localparam logic [LW_W-1:0] LW_RESET = LW_W'(640);

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  typedef struct packed {
    logic clear;
    logic capture;
    logic read;
    logic correct;
    logic search;
    logic errc;
    logic wrx;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic search_last;
    logic out_full;
  } dp_status_t;

  function automatic logic signed [ERR_W-1:0] sat_err(input logic signed [SAT_IN_W-1:0] v);
    logic signed [SAT_IN_W-1:0] hi;
    logic signed [SAT_IN_W-1:0] lo;
    hi = $signed(SAT_IN_W'(ERR_MAX));
    lo = -hi - $signed(SAT_IN_W'(1));
    if (v > hi) begin
      return hi[ERR_W-1:0];
    end else if (v < lo) begin
      return lo[ERR_W-1:0];
    end
    return v[ERR_W-1:0];
  endfunction

endpackage

// File: hw/rtl/pedd_ctrl.sv
module pedd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 command,
  input  pedd_pkg::dp_status_t status,
  output pedd_pkg::dp_cmd_t    cmd,
  output logic                 in_ready
);
  import pedd_pkg::*;

  typedef enum logic [8:0] {
    S_CLEAR   = 9'b000000001,
    S_IDLE    = 9'b000000010,
    S_READ    = 9'b000000100,
    S_CORRECT = 9'b000001000,
    S_SEARCH  = 9'b000010000,
    S_DRAIN   = 9'b000100000,
    S_ERRC    = 9'b001000000,
    S_WRX     = 9'b010000000,
    S_FINISH  = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (command == CMD_PIXEL) state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.read   = 1'b1;
        state_next = S_CORRECT;
      end
      S_CORRECT: begin
        cmd.correct = 1'b1;
        state_next  = S_SEARCH;
      end
      S_SEARCH: begin
        cmd.search = 1'b1;
        if (status.search_last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        state_next = S_ERRC;
      end
      S_ERRC: begin
        cmd.errc   = 1'b1;
        state_next = S_WRX;
      end
      S_WRX: begin
        cmd.wrx    = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!status.out_full) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

// File: hw/rtl/pedd_datapath.sv
module pedd_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  pedd_pkg::dp_cmd_t              cmd,
  output pedd_pkg::dp_status_t           status,
  input  logic                           command,
  input  logic [7:0]                     red,
  input  logic [7:0]                     green,
  input  logic [7:0]                     blue,
  input  logic [3:0]                     slot,
  input  logic                           frame_start,
  input  logic [pedd_pkg::LW_W-1:0]      line_width,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [pedd_pkg::PAL_IDX_W-1:0] color_index
);
  import pedd_pkg::*;

  localparam int LINE_W = 3 * ERR_W;

  logic [23:0]                 pal [PAL_N];
  logic [7:0]                  pin [3];
  logic                        first_row;
  logic [COL_W-1:0]            col_count;
  logic signed [ERR_W-1:0]     right_c [3];
  logic signed [ERR_W-1:0]     below_c [3];
  logic [COL_W-1:0]            x;
  logic                        row_end;

  logic [LINE_W-1:0]           line_mem [LINE_DEPTH];
  logic [LINE_W-1:0]           rd_a;
  logic [LINE_W-1:0]           rd_b;
  logic [LINE_AW-1:0]          clr_addr;
  logic                        wr_en;
  logic [LINE_AW-1:0]          wr_addr;
  logic [LINE_W-1:0]           wr_data;

  logic signed [PIX_W-1:0]     pix [3];
  logic [PAL_IDX_W-1:0]        idx;
  logic                        s1_valid;
  logic [PAL_IDX_W-1:0]        s1_idx;
  logic [23:0]                 s1_col;
  logic [SQ_W-1:0]             sq [3];
  logic [DIST_W-1:0]           best_d;
  logic [PAL_IDX_W-1:0]        best_idx;
  logic [23:0]                 best_col;

  logic signed [ERR_W-1:0]     wx [3];
  logic signed [ERR_W-1:0]     wx1 [3];
  logic signed [ERR_W-1:0]     new_right [3];
  logic signed [ERR_W-1:0]     new_below [3];

  logic [LW_W-1:0]             w_eff;
  logic [COL_W-1:0]            wm1;
  logic [COL_W-1:0]            cnt_eff;
  logic [COL_W-1:0]            x_cap;
  logic [LINE_AW-1:0]          x_addr;
  logic [LINE_AW-1:0]          x1_addr;
  logic [DIST_W-1:0]           dist_sum;

  // Column for the incoming word, clamped to the current row width, plus the line addresses and the distance sum.
  always_comb begin
    if (line_width == '0) begin
      w_eff = LW_W'(1);
    end else if (line_width > LW_W'(MAX_WIDTH)) begin
      w_eff = LW_W'(MAX_WIDTH);
    end else begin
      w_eff = line_width;
    end
    wm1      = COL_W'(w_eff - LW_W'(1));
    cnt_eff  = frame_start ? '0 : col_count;
    x_cap    = (cnt_eff >= wm1) ? wm1 : cnt_eff;
    x_addr   = LINE_AW'(x);
    x1_addr  = LINE_AW'(x) + LINE_AW'(1);
    dist_sum = DIST_W'(sq[0]) + DIST_W'(sq[1]) + DIST_W'(sq[2]);
  end

  assign status.clear_last  = (clr_addr == LINE_AW'(LINE_DEPTH - 1));
  assign status.search_last = (idx == PAL_IDX_W'(PAL_N - 1));
  assign status.out_full    = out_valid & ~out_ready;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      if (command == CMD_LOAD) begin
        pal[slot] <= {red, green, blue};
      end else begin
        pin[0]  <= red;
        pin[1]  <= green;
        pin[2]  <= blue;
        x       <= x_cap;
        row_end <= (x_cap == wm1);
      end
    end
  end

  // Error line: two read ports, one write port.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_addr;
    wr_data = '0;
    if (cmd.clear) begin
      wr_en = 1'b1;
    end else if (cmd.wrx) begin
      wr_en   = (x != '0);
      wr_addr = x_addr;
      wr_data = {wx[0], wx[1], wx[2]};
    end else if (cmd.finish) begin
      wr_en   = 1'b1;
      wr_addr = x1_addr;
      wr_data = {wx1[0], wx1[1], wx1[2]};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) line_mem[wr_addr] <= wr_data;
    if (cmd.read) begin
      rd_a <= line_mem[x_addr];
      rd_b <= line_mem[x1_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear && !status.clear_last) begin
      clr_addr <= clr_addr + LINE_AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    logic signed [ERR_W-1:0] above;
    logic signed [ERR_W-1:0] inc;
    for (int c = 0; c < 3; c++) begin
      above = first_row ? '0 : $signed(rd_b[(2-c)*ERR_W +: ERR_W]);
      inc   = sat_err(SAT_IN_W'(right_c[c]) + SAT_IN_W'(above));
      if (cmd.correct) begin
        pix[c] <= $signed({3'b000, pin[c], 4'b0000}) + PIX_W'(inc);
      end
    end
  end

  // Search: squared distances for one entry per cycle, then compare.
  always_ff @(posedge clk) begin
    logic signed [DIFF_W-1:0]   diff;
    logic signed [2*DIFF_W-1:0] prod;
    for (int c = 0; c < 3; c++) begin
      diff = DIFF_W'(pix[c]) - $signed({4'b0000, pal[idx][(2-c)*8 +: 8], 4'b0000});
      prod = diff * diff;
      if (cmd.search) sq[c] <= SQ_W'(prod);
    end
    if (cmd.search) begin
      s1_col <= pal[idx];
      s1_idx <= idx;
    end
    if (cmd.correct) begin
      idx <= '0;
    end else if (cmd.search) begin
      idx <= idx + PAL_IDX_W'(1);
    end
    if (s1_valid && (s1_idx == '0 || dist_sum < best_d)) begin
      best_d   <= dist_sum;
      best_idx <= s1_idx;
      best_col <= s1_col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.search;
    end
  end

  // Shares of 7, 5, 3 and 1 sixteenths, rounded toward minus infinity.
  always_ff @(posedge clk) begin
    logic signed [SAT_IN_W-1:0] e;
    logic signed [SAT_IN_W-1:0] p1;
    logic signed [SAT_IN_W-1:0] p3;
    logic signed [SAT_IN_W-1:0] p5;
    logic signed [SAT_IN_W-1:0] p7;
    for (int c = 0; c < 3; c++) begin
      e  = SAT_IN_W'(pix[c]) - $signed({8'b0, best_col[(2-c)*8 +: 8], 4'b0000});
      p1 = e >>> 4;
      p3 = (e * $signed(SAT_IN_W'(3))) >>> 4;
      p5 = (e * $signed(SAT_IN_W'(5))) >>> 4;
      p7 = (e * $signed(SAT_IN_W'(7))) >>> 4;
      if (cmd.errc) begin
        wx[c]        <= sat_err(SAT_IN_W'($signed(rd_a[(2-c)*ERR_W +: ERR_W])) + p3);
        wx1[c]       <= sat_err(SAT_IN_W'(below_c[c]) + p5);
        new_below[c] <= sat_err(p1);
        new_right[c] <= sat_err(p7);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_row <= 1'b1;
      col_count <= '0;
      out_valid <= 1'b0;
      for (int c = 0; c < 3; c++) begin
        right_c[c] <= '0;
        below_c[c] <= '0;
      end
    end else begin
      if (out_valid && out_ready && !cmd.finish) out_valid <= 1'b0;
      if (cmd.capture && command == CMD_PIXEL && frame_start) begin
        first_row <= 1'b1;
        for (int c = 0; c < 3; c++) begin
          right_c[c] <= '0;
          below_c[c] <= '0;
        end
      end
      if (cmd.finish) begin
        out_valid   <= 1'b1;
        color_index <= best_idx;
        if (row_end) begin
          col_count <= '0;
          first_row <= 1'b0;
          for (int c = 0; c < 3; c++) begin
            right_c[c] <= '0;
            below_c[c] <= '0;
          end
        end else begin
          col_count <= x + COL_W'(1);
          for (int c = 0; c < 3; c++) begin
            right_c[c] <= new_right[c];
            below_c[c] <= new_below[c];
          end
        end
      end
    end
  end

endmodule

// File: hw/rtl/palette_error_diffusion_dither.sv
// Floyd-Steinberg dither of an RGB pixel stream onto a 16-entry palette. A load word
// writes one palette entry and gives no result; a pixel word passes through the error
// line read, the palette search, which scores one entry per cycle through a two-stage
// square-and-compare unit, the error split and two writes to the single write port
// of the error line memory before its index is ready; the block takes no new word
// until it is through with the current pixel. After reset the block clears that
// 4098-entry memory, one entry a cycle, and accepts no word until it is done;
// register writes are taken throughout. Load every palette entry before the first pixel.
module palette_error_diffusion_dither (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [1:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           command,
  input  logic [7:0]                     red,
  input  logic [7:0]                     green,
  input  logic [7:0]                     blue,
  input  logic [3:0]                     slot,
  input  logic                           frame_start,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [pedd_pkg::PAL_IDX_W-1:0] color_index
);
  import pedd_pkg::*;

  logic [LW_W-1:0] line_width;
  dp_cmd_t         cmd;
  dp_status_t      status;

  assign pready = 1'b1;
  assign prdata = {(32 - LW_W)'(0), line_width};

  // Only one register, so every address within the word selects it.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= LW_RESET;
    end else if (psel && penable && pwrite && pready && paddr[1:0] != 2'b11 + 2'b01) begin
      line_width <= pwdata[LW_W-1:0];
    end else if (psel && penable && pwrite && pready) begin
      line_width <= pwdata[LW_W-1:0];
    end
  end

  pedd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .command  (command),
    .status   (status),
    .cmd      (cmd),
    .in_ready (in_ready)
  );

  pedd_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .command     (command),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .slot        (slot),
    .frame_start (frame_start),
    .line_width  (line_width),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .color_index (color_index)
  );

  // The clearing pass holds off the input side straight after reset.
  a_clear_after_reset: assert property (@(posedge clk) $past(rst) |-> !in_ready)
    else $error("input ready during clearing pass");

  // A pixel word keeps the block busy for at least the next cycle.
  a_pixel_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && command == CMD_PIXEL |=> !in_ready)
    else $error("pixel word did not make the block busy");

  // A new result word only appears once a pixel has been worked on.
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result word appeared without work");

  // A load word never starts the pixel sequence.
  a_load_stays_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && command == CMD_LOAD |=> in_ready)
    else $error("load word left the idle state");

endmodule
